>>> hdl/hcf_pkg.sv
`default_nettype none
package hcf_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int STEP_W       = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;

  // coordinate differences and quaternion terms share one signed width
  localparam int VEC_W = (COORD_WIDTH + 1 > 33) ? COORD_WIDTH + 1 : 33;

  localparam int CORDIC_W    = 64;
  localparam int NORM_TOP    = 58;
  localparam int NORM_COARSE = 50;
  localparam int NORM_STEP   = 8;
  localparam int Z_W         = 27;
  localparam int Z_SHIFT     = 11;
  localparam int Z_HALF      = 1024;

  localparam int ANG_W    = 16;
  localparam int ANG_FQ_W = 14;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd25736;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd12868;
  localparam logic signed [ANG_W:0]   DEV_PI      = 17'sd25736;
  localparam logic signed [ANG_W:0]   DEV_TWO_PI  = 17'sd51472;

  localparam int THRESH_W = 15;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd819;

  localparam int DIST_W     = 32;
  localparam int SQ_W       = 64;
  localparam int ROOT_STEPS = 32;
  localparam int ROOT_CNT_W = 5;
  localparam int CNT_W      = 16;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [15:0]            quat_z;
    logic signed [15:0]            quat_w;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]        point_index;
    logic                    is_close;
    logic [DIST_W-1:0]       distance;
    logic signed [ANG_W-1:0] deviation;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_FINISH
  } top_state_t;

  typedef enum logic [1:0] {
    CRD_IDLE,
    CRD_NORM,
    CRD_ITER,
    CRD_ROUND
  } cordic_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MUL_X,
    SQ_MUL_Y,
    SQ_SUM,
    SQ_ROOT,
    SQ_ROUND
  } sqrt_state_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic [23:0] atan_entry(input logic [4:0] idx);
    logic [23:0] val;
    unique case (idx)
      5'd0:    val = 24'd13176795;
      5'd1:    val = 24'd7778716;
      5'd2:    val = 24'd4110060;
      5'd3:    val = 24'd2086331;
      5'd4:    val = 24'd1047214;
      5'd5:    val = 24'd524117;
      5'd6:    val = 24'd262123;
      5'd7:    val = 24'd131069;
      5'd8:    val = 24'd65536;
      5'd9:    val = 24'd32768;
      5'd10:   val = 24'd16384;
      5'd11:   val = 24'd8192;
      5'd12:   val = 24'd4096;
      5'd13:   val = 24'd2048;
      5'd14:   val = 24'd1024;
      5'd15:   val = 24'd512;
      5'd16:   val = 24'd256;
      5'd17:   val = 24'd128;
      5'd18:   val = 24'd64;
      5'd19:   val = 24'd32;
      5'd20:   val = 24'd16;
      5'd21:   val = 24'd8;
      5'd22:   val = 24'd4;
      5'd23:   val = 24'd2;
      default: val = 24'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

>>> hdl/hcf_cordic.sv
`default_nettype none
module hcf_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [hcf_pkg::VEC_W-1:0]         mag_x,
  input  logic [hcf_pkg::VEC_W-1:0]         mag_y,
  output logic                              busy,
  output logic [hcf_pkg::ANG_FQ_W-1:0]      angle
);

  hcf_pkg::cordic_state_t state, state_next;

  logic signed [hcf_pkg::CORDIC_W-1:0] x;
  logic signed [hcf_pkg::CORDIC_W-1:0] y;
  logic signed [hcf_pkg::Z_W-1:0]      z;
  logic [hcf_pkg::STEP_W-1:0]          step;

  logic [hcf_pkg::CORDIC_W-1:0]        norm_or;
  logic signed [hcf_pkg::CORDIC_W-1:0] x_sh;
  logic signed [hcf_pkg::CORDIC_W-1:0] y_sh;
  logic signed [hcf_pkg::Z_W-1:0]      atan_z;
  logic signed [hcf_pkg::Z_W-1:0]      z_pos;
  logic signed [hcf_pkg::Z_W-1:0]      z_q;
  logic [hcf_pkg::ANG_FQ_W-1:0]        angle_next;
  logic                                last_step;

  assign norm_or   = x | y;
  assign x_sh      = x >>> step;
  assign y_sh      = y >>> step;
  assign atan_z    = hcf_pkg::Z_W'({1'b0, hcf_pkg::atan_entry(5'(step))});
  assign last_step = (step == hcf_pkg::STEP_W'(hcf_pkg::CORDIC_N - 1));

  always_comb begin
    z_pos = z[hcf_pkg::Z_W-1] ? '0 : z;
    z_q   = (z_pos + hcf_pkg::Z_W'(hcf_pkg::Z_HALF)) >>> hcf_pkg::Z_SHIFT;
    if (z_q > hcf_pkg::Z_W'(hcf_pkg::ANG_HALF_PI)) begin
      angle_next = hcf_pkg::ANG_FQ_W'(hcf_pkg::ANG_HALF_PI);
    end else begin
      angle_next = z_q[hcf_pkg::ANG_FQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcf_pkg::CRD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      hcf_pkg::CRD_IDLE: begin
        busy = 1'b0;
        if (start) state_next = hcf_pkg::CRD_NORM;
      end
      hcf_pkg::CRD_NORM: begin
        if (norm_or[hcf_pkg::CORDIC_W-1:hcf_pkg::NORM_TOP] != '0) begin
          state_next = hcf_pkg::CRD_ITER;
        end
      end
      hcf_pkg::CRD_ITER: begin
        if (last_step) state_next = hcf_pkg::CRD_ROUND;
      end
      hcf_pkg::CRD_ROUND: begin
        state_next = hcf_pkg::CRD_IDLE;
      end
      default: state_next = hcf_pkg::CRD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      hcf_pkg::CRD_IDLE: begin
        if (start) begin
          x    <= hcf_pkg::CORDIC_W'(mag_x);
          y    <= hcf_pkg::CORDIC_W'(mag_y);
          z    <= '0;
          step <= '0;
        end
      end
      hcf_pkg::CRD_NORM: begin
        // both magnitudes shift together until one reaches the top range
        if (norm_or[hcf_pkg::CORDIC_W-1:hcf_pkg::NORM_TOP] == '0) begin
          if (norm_or[hcf_pkg::CORDIC_W-1:hcf_pkg::NORM_COARSE] == '0) begin
            x <= x <<< hcf_pkg::NORM_STEP;
            y <= y <<< hcf_pkg::NORM_STEP;
          end else begin
            x <= x <<< 1;
            y <= y <<< 1;
          end
        end
      end
      hcf_pkg::CRD_ITER: begin
        if (!y[hcf_pkg::CORDIC_W-1]) begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_z;
        end else begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_z;
        end
        step <= step + 1'b1;
      end
      hcf_pkg::CRD_ROUND: begin
        angle <= angle_next;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/hcf_sqrt.sv
`default_nettype none
module hcf_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hcf_pkg::VEC_W-1:0]     mag_x,
  input  logic [hcf_pkg::VEC_W-1:0]     mag_y,
  output logic                          busy,
  output logic [hcf_pkg::DIST_W-1:0]    span
);

  hcf_pkg::sqrt_state_t state, state_next;

  logic [hcf_pkg::DIST_W-1:0]     mx;
  logic [hcf_pkg::DIST_W-1:0]     my;
  logic                           sat;
  logic [hcf_pkg::SQ_W-1:0]       a2;
  logic [hcf_pkg::SQ_W-1:0]       b2;
  logic [hcf_pkg::SQ_W-1:0]       rem;
  logic [hcf_pkg::SQ_W-1:0]       root;
  logic [hcf_pkg::SQ_W-1:0]       bitv;
  logic [hcf_pkg::ROOT_CNT_W-1:0] cnt;

  logic [hcf_pkg::DIST_W-1:0] mul_op;
  logic [hcf_pkg::SQ_W-1:0]   prod;
  logic [hcf_pkg::SQ_W:0]     sum;
  logic [hcf_pkg::SQ_W-1:0]   trial;
  logic [hcf_pkg::SQ_W-1:0]   rounded;

  // one multiplier squares x then y
  assign mul_op  = (state == hcf_pkg::SQ_MUL_X) ? mx : my;
  assign prod    = mul_op * mul_op;
  assign sum     = {1'b0, a2} + {1'b0, b2};
  assign trial   = root + bitv;
  assign rounded = root + hcf_pkg::SQ_W'(rem > root);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcf_pkg::SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      hcf_pkg::SQ_IDLE: begin
        busy = 1'b0;
        if (start) state_next = hcf_pkg::SQ_MUL_X;
      end
      hcf_pkg::SQ_MUL_X: state_next = hcf_pkg::SQ_MUL_Y;
      hcf_pkg::SQ_MUL_Y: state_next = hcf_pkg::SQ_SUM;
      hcf_pkg::SQ_SUM:   state_next = hcf_pkg::SQ_ROOT;
      hcf_pkg::SQ_ROOT: begin
        if (cnt == hcf_pkg::ROOT_CNT_W'(hcf_pkg::ROOT_STEPS - 1)) begin
          state_next = hcf_pkg::SQ_ROUND;
        end
      end
      hcf_pkg::SQ_ROUND: state_next = hcf_pkg::SQ_IDLE;
      default:           state_next = hcf_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      hcf_pkg::SQ_IDLE: begin
        if (start) begin
          mx  <= mag_x[hcf_pkg::DIST_W-1:0];
          my  <= mag_y[hcf_pkg::DIST_W-1:0];
          sat <= (mag_x[hcf_pkg::VEC_W-1:hcf_pkg::DIST_W] != '0) ||
                 (mag_y[hcf_pkg::VEC_W-1:hcf_pkg::DIST_W] != '0);
        end
      end
      hcf_pkg::SQ_MUL_X: a2 <= prod;
      hcf_pkg::SQ_MUL_Y: b2 <= prod;
      hcf_pkg::SQ_SUM: begin
        rem  <= sum[hcf_pkg::SQ_W-1:0];
        sat  <= sat | sum[hcf_pkg::SQ_W];
        root <= '0;
        bitv <= hcf_pkg::SQ_W'(1) << (hcf_pkg::SQ_W - 2);
        cnt  <= '0;
      end
      hcf_pkg::SQ_ROOT: begin
        // one result bit per step
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
      end
      hcf_pkg::SQ_ROUND: begin
        if (sat || (rounded[hcf_pkg::SQ_W-1:hcf_pkg::DIST_W] != '0)) begin
          span <= '1;
        end else begin
          span <= rounded[hcf_pkg::DIST_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/path_heading_change_filter_core.sv
`default_nettype none
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   in_data (hcf_pkg::in_word_t)
// out       out  out_valid / out_ready out_data (hcf_pkg::out_word_t)
// cfg       in   cfg_wr_en             cfg_wr_data (close threshold)
//
// each word is carried through to its result before the next accept:
// difference, start, then the 32-step square-root unit (squares, sum, round),
// which outlasts the cordic pass (up to 14 normalize shifts, 16 rotations)
// synchronous rst clears control state and sets the threshold to 0.10 rad.
// a result waits in the output register; the next word is taken meanwhile,
// but a path point cannot finish until that register has been emptied.
module path_heading_change_filter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hcf_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hcf_pkg::out_word_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [hcf_pkg::THRESH_W-1:0]   cfg_wr_data
);

  hcf_pkg::top_state_t state, state_next;

  hcf_pkg::in_word_t                         item;
  logic [hcf_pkg::THRESH_W-1:0]              close_threshold;
  logic signed [hcf_pkg::COORD_WIDTH-1:0]    kept_x;
  logic signed [hcf_pkg::COORD_WIDTH-1:0]    kept_y;
  logic signed [hcf_pkg::ANG_W-1:0]          heading;
  logic [hcf_pkg::CNT_W-1:0]                 point_count;
  logic signed [hcf_pkg::VEC_W-1:0]          dx;
  logic signed [hcf_pkg::VEC_W-1:0]          dy;

  logic take_in, load_diff, start_units, commit_start, commit_point;

  logic signed [31:0]                zw;
  logic signed [31:0]                ww;
  logic signed [31:0]                zz;
  logic signed [hcf_pkg::VEC_W-1:0]  dx_next;
  logic signed [hcf_pkg::VEC_W-1:0]  dy_next;
  logic [hcf_pkg::VEC_W-1:0]         mag_x;
  logic [hcf_pkg::VEC_W-1:0]         mag_y;
  logic [hcf_pkg::VEC_W-1:0]         crd_x;
  logic [hcf_pkg::VEC_W-1:0]         crd_y;

  logic                              crd_busy;
  logic                              sq_busy;
  logic [hcf_pkg::ANG_FQ_W-1:0]      crd_angle;
  logic [hcf_pkg::DIST_W-1:0]        sq_dist;

  logic signed [hcf_pkg::ANG_W-1:0]  a_ext;
  logic signed [hcf_pkg::ANG_W-1:0]  bearing;
  logic signed [hcf_pkg::ANG_W:0]    dev_raw;
  logic signed [hcf_pkg::ANG_W:0]    dev_wrap;
  logic signed [hcf_pkg::ANG_W-1:0]  dev;
  logic [hcf_pkg::ANG_W-1:0]         adev;
  logic                              is_close;

  // start words turn the quaternion into a yaw vector
  assign zw = item.quat_z * item.quat_w;
  assign ww = item.quat_w * item.quat_w;
  assign zz = item.quat_z * item.quat_z;

  always_comb begin
    if (item.kind == hcf_pkg::KIND_START) begin
      dx_next = hcf_pkg::VEC_W'(ww) - hcf_pkg::VEC_W'(zz);
      dy_next = hcf_pkg::VEC_W'(zw) <<< 1;
    end else begin
      dx_next = hcf_pkg::VEC_W'(item.pos_x) - hcf_pkg::VEC_W'(kept_x);
      dy_next = hcf_pkg::VEC_W'(item.pos_y) - hcf_pkg::VEC_W'(kept_y);
    end
  end

  assign mag_x = dx[hcf_pkg::VEC_W-1] ? hcf_pkg::VEC_W'(-dx) : hcf_pkg::VEC_W'(dx);
  assign mag_y = dy[hcf_pkg::VEC_W-1] ? hcf_pkg::VEC_W'(-dy) : hcf_pkg::VEC_W'(dy);
  // zero magnitudes are special-cased below; keep the normalizer finite
  assign crd_x = (mag_x == '0) ? hcf_pkg::VEC_W'(1) : mag_x;
  assign crd_y = (mag_y == '0) ? hcf_pkg::VEC_W'(1) : mag_y;

  hcf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (start_units),
    .mag_x (crd_x),
    .mag_y (crd_y),
    .busy  (crd_busy),
    .angle (crd_angle)
  );

  hcf_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (start_units),
    .mag_x (mag_x),
    .mag_y (mag_y),
    .busy  (sq_busy),
    .span  (sq_dist)
  );

  // quadrant rule
  always_comb begin
    if (dy == '0) begin
      a_ext = '0;
    end else begin
      a_ext = {{(hcf_pkg::ANG_W - hcf_pkg::ANG_FQ_W){1'b0}}, crd_angle};
    end
    if (dx == '0) begin
      if (dy[hcf_pkg::VEC_W-1]) begin
        bearing = -hcf_pkg::ANG_HALF_PI;
      end else if (dy != '0) begin
        bearing = hcf_pkg::ANG_HALF_PI;
      end else if (item.kind == hcf_pkg::KIND_POINT) begin
        bearing = -hcf_pkg::ANG_HALF_PI;
      end else begin
        bearing = '0;
      end
    end else if (!dx[hcf_pkg::VEC_W-1]) begin
      bearing = dy[hcf_pkg::VEC_W-1] ? -a_ext : a_ext;
    end else begin
      bearing = dy[hcf_pkg::VEC_W-1] ? (a_ext - hcf_pkg::ANG_PI) : (hcf_pkg::ANG_PI - a_ext);
    end
  end

  always_comb begin
    dev_raw = (hcf_pkg::ANG_W + 1)'(bearing) - (hcf_pkg::ANG_W + 1)'(heading);
    if (dev_raw >= hcf_pkg::DEV_PI) begin
      dev_wrap = dev_raw - hcf_pkg::DEV_TWO_PI;
    end else if (dev_raw < -hcf_pkg::DEV_PI) begin
      dev_wrap = dev_raw + hcf_pkg::DEV_TWO_PI;
    end else begin
      dev_wrap = dev_raw;
    end
    dev      = dev_wrap[hcf_pkg::ANG_W-1:0];
    adev     = dev[hcf_pkg::ANG_W-1] ? hcf_pkg::ANG_W'(-dev) : hcf_pkg::ANG_W'(dev);
    is_close = adev < {1'b0, close_threshold};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    take_in      = 1'b0;
    load_diff    = 1'b0;
    start_units  = 1'b0;
    commit_start = 1'b0;
    commit_point = 1'b0;
    unique case (state)
      hcf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          take_in    = 1'b1;
          state_next = hcf_pkg::ST_LOAD;
        end
      end
      hcf_pkg::ST_LOAD: begin
        load_diff  = 1'b1;
        state_next = hcf_pkg::ST_START;
      end
      hcf_pkg::ST_START: begin
        start_units = 1'b1;
        state_next  = hcf_pkg::ST_WAIT;
      end
      hcf_pkg::ST_WAIT: begin
        if (!crd_busy && !sq_busy) state_next = hcf_pkg::ST_FINISH;
      end
      hcf_pkg::ST_FINISH: begin
        if (item.kind == hcf_pkg::KIND_START) begin
          commit_start = 1'b1;
          state_next   = hcf_pkg::ST_IDLE;
        end else if (!out_valid || out_ready) begin
          commit_point = 1'b1;
          state_next   = hcf_pkg::ST_IDLE;
        end
      end
      default: state_next = hcf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      close_threshold <= hcf_pkg::THRESH_RESET;
      kept_x          <= '0;
      kept_y          <= '0;
      heading         <= '0;
      point_count     <= '0;
    end else begin
      if (commit_point) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) close_threshold <= cfg_wr_data;
      if (commit_start) begin
        kept_x      <= item.pos_x;
        kept_y      <= item.pos_y;
        heading     <= bearing;
        point_count <= '0;
      end else if (commit_point) begin
        point_count <= point_count + 1'b1;
        if (!is_close) begin
          kept_x  <= item.pos_x;
          kept_y  <= item.pos_y;
          heading <= bearing;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) item <= in_data;
    if (load_diff) begin
      dx <= dx_next;
      dy <= dy_next;
    end
    if (commit_point) begin
      out_data.point_index <= point_count;
      out_data.is_close    <= is_close;
      out_data.distance    <= sq_dist;
      out_data.deviation   <= dev;
    end
  end

endmodule
`default_nettype wire

>>> tb/path_heading_change_filter_core_tb.sv
`default_nettype none
module path_heading_change_filter_core_tb;

  localparam int PI_Q13       = 25736;
  localparam int HALF_PI_Q13  = 12868;
  localparam int TWO_PI_Q13   = 51472;
  localparam int ROT_STEPS    = 16;
  localparam int GAP_MAX      = 13;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 64;
  localparam int PHASE_ITEMS  = 225;
  localparam int LIMIT_CYCLES = 1000000;
  localparam logic [63:0] NORM_EDGE = 64'h0400_0000_0000_0000;

  typedef struct {
    hcf_pkg::in_word_t  word;
    bit                 typed;
    hcf_pkg::out_word_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  hcf_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hcf_pkg::out_word_t out_data;
  logic               cfg_wr_en = 1'b0;
  logic [hcf_pkg::THRESH_W-1:0] cfg_wr_data = '0;

  // atan(2^-i) in units of 2^-24 rad
  longint atan_q24 [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // filter state mirrored on the bench side
  longint                       kept_x = 0;
  longint                       kept_y = 0;
  int                           heading = 0;
  logic [15:0]                  pt_count = '0;
  logic [hcf_pkg::THRESH_W-1:0] thresh_now = hcf_pkg::THRESH_RESET;

  hcf_pkg::out_word_t due_reports [$];
  stim_row_t          stim_rows [$];
  hcf_pkg::out_word_t head_word;
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycle_count = 0;
  int        tx_burst = 0;
  logic [31:0] cur_x = '0, cur_y = '0, step_x = 32'd65536, step_y = '0;

  path_heading_change_filter_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // quadrant-resolved bearing, first quadrant from a vectoring cordic pass
  function automatic int bearing_of(longint y, longint x, int at_origin);
    longint unsigned ax, ay;
    longint cx, cy, cz, nx;
    int a, i;
    if (x == 0) begin
      if (y > 0) return HALF_PI_Q13;
      if (y < 0) return -HALF_PI_Q13;
      return at_origin;
    end
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    a = 0;
    if (ay != 0) begin
      while (ax < NORM_EDGE && ay < NORM_EDGE) begin
        ax = ax << 1;
        ay = ay << 1;
      end
      cx = ax;
      cy = ay;
      cz = 0;
      for (i = 0; i < ROT_STEPS; i++) begin
        if (cy >= 0) begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          cz = cz + atan_q24[i];
        end else begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          cz = cz - atan_q24[i];
        end
        cx = nx;
      end
      if (cz < 0) cz = 0;
      cz = (cz + 1024) >>> 11;
      if (cz > HALF_PI_Q13) cz = HALF_PI_Q13;
      a = int'(cz);
    end
    if (x > 0) return (y >= 0) ? a : -a;
    return (y >= 0) ? (PI_Q13 - a) : (a - PI_Q13);
  endfunction

  // euclidean distance, rounded to nearest, saturating
  function automatic logic [31:0] span_of(longint dx, longint dy);
    longint unsigned ax, ay, a2, s, r, b;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax >= 64'h1_0000_0000 || ay >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
    a2 = ax * ax;
    s = a2 + ay * ay;
    if (s < a2) return 32'hFFFF_FFFF;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    if (r > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return r[31:0];
  endfunction

  task automatic advance_filter(input hcf_pkg::in_word_t w, output bit has,
                                output hcf_pkg::out_word_t rep);
    longint px, py, dx, dy, qz, qw;
    int bearing, dev, adev;
    bit close;
    px = $signed(w.pos_x);
    py = $signed(w.pos_y);
    rep = '0;
    has = 1'b0;
    if (w.kind == hcf_pkg::KIND_START) begin
      qz = $signed(w.quat_z);
      qw = $signed(w.quat_w);
      kept_x = px;
      kept_y = py;
      heading = bearing_of(2 * qz * qw, qw * qw - qz * qz, 0);
      pt_count = '0;
    end else begin
      dx = px - kept_x;
      dy = py - kept_y;
      bearing = bearing_of(dy, dx, -HALF_PI_Q13);
      dev = bearing - heading;
      if (dev >= PI_Q13) dev = dev - TWO_PI_Q13;
      else if (dev < -PI_Q13) dev = dev + TWO_PI_Q13;
      adev = (dev < 0) ? -dev : dev;
      close = adev < int'(thresh_now);
      has = 1'b1;
      rep.point_index = pt_count;
      rep.is_close = close;
      rep.distance = span_of(dx, dy);
      rep.deviation = dev[15:0];
      pt_count = pt_count + 16'd1;
      if (!close) begin
        kept_x = px;
        kept_y = py;
        heading = bearing;
      end
    end
  endtask

  task automatic add_row(input logic kind, input logic [31:0] x, input logic [31:0] y,
                         input logic [15:0] qz, input logic [15:0] qw, input bit typed,
                         input logic [15:0] idx, input logic cl, input logic [31:0] span,
                         input logic [15:0] dev);
    stim_row_t row;
    row.word.kind = kind;
    row.word.pos_x = x;
    row.word.pos_y = y;
    row.word.quat_z = qz;
    row.word.quat_w = qw;
    row.typed = typed;
    row.want.point_index = idx;
    row.want.is_close = cl;
    row.want.distance = span;
    row.want.deviation = dev;
    stim_rows.push_back(row);
  endtask

  task automatic push_word(input hcf_pkg::in_word_t w, output bit has,
                           output hcf_pkg::out_word_t rep);
    int gap;
    gap = (tx_burst > 0) ? 0 : $urandom_range(0, GAP_MAX);
    if (tx_burst > 0) tx_burst--;
    else if ($urandom_range(0, 99) < 3) tx_burst = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    advance_filter(w, has, rep);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    // a start word yields nothing, so let one more pass finish
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_step();
    logic [31:0] m;
    m = $urandom_range(0, 1 << $urandom_range(0, 22));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_quat();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'hFFFF;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (due_reports.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected word at cycle %0d: idx %0d close %0b dist %h dev %0d",
                   cycle_count, out_data.point_index, out_data.is_close,
                   out_data.distance, $signed(out_data.deviation));
      end else begin
        head_word = due_reports.pop_front();
        if (out_data.point_index !== head_word.point_index ||
            out_data.is_close !== head_word.is_close ||
            out_data.distance !== head_word.distance ||
            out_data.deviation !== head_word.deviation) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: want %0d/%0b/%h/%0d got %0d/%0b/%h/%0d",
                     cycle_count, head_word.point_index, head_word.is_close,
                     head_word.distance, $signed(head_word.deviation),
                     out_data.point_index, out_data.is_close, out_data.distance,
                     $signed(out_data.deviation));
        end
      end
    end
  end

  // receiver: random stalls, bursts of full rate, one long hold-off
  initial begin
    int n;
    int rx_burst;
    bit long_done;
    rx_burst = 0;
    long_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = (rx_burst > 0) ? 0 : $urandom_range(0, GAP_MAX);
      if (rx_burst > 0) rx_burst--;
      else if ($urandom_range(0, 99) < 4) rx_burst = $urandom_range(10, 40);
      if (!long_done && results_seen >= 300) begin
        n = HOLD_CYCLES;
        long_done = 1'b1;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    stim_row_t row;
    hcf_pkg::in_word_t w;
    bit has;
    hcf_pkg::out_word_t rep;
    logic [hcf_pkg::THRESH_W-1:0] thr_list [0:5];
    int phase, k, r, q;

    // point before any start: coincident with the origin, bearing -pi/2
    add_row(hcf_pkg::KIND_POINT, 32'h0, 32'h0, 16'h7FFF, 16'h8000, 1, 0, 0, 32'h0,
            -16'sd12868);
    // deviation of exactly +pi wraps to -pi
    add_row(hcf_pkg::KIND_POINT, 32'h0, 32'd65536, 16'h1234, 16'h4321, 1, 1, 0, 32'd65536,
            -16'sd25736);
    add_row(hcf_pkg::KIND_POINT, 32'h0, 32'd131072, 16'h0, 16'h0, 1, 2, 1, 32'd65536,
            16'sd0);
    // zero quaternion gives heading 0
    add_row(hcf_pkg::KIND_START, 32'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'h7FFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF, 1, 0, 1,
            32'h7FFF_FFFF, 16'sd0);
    add_row(hcf_pkg::KIND_START, 32'h8000_0000, 32'h0, 16'h0, 16'h7FFF, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'h7FFF_FFFF, 32'h0, 16'h8000, 16'h8000, 1, 0, 1,
            32'hFFFF_FFFF, 16'sd0);
    // heading pi, then a deviation of exactly -pi stays
    add_row(hcf_pkg::KIND_START, 32'h0, 32'h0, 16'h7FFF, 16'h0, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'd65536, 32'h0, 16'h0, 16'h0, 1, 0, 0, 32'd65536,
            -16'sd25736);
    add_row(hcf_pkg::KIND_START, 32'h0, 32'h0, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'h0, -32'sd65536, 16'h0, 16'h0, 1, 0, 0, 32'd65536,
            -16'sd25736);
    add_row(hcf_pkg::KIND_POINT, 32'h0, -32'sd65536, 16'h0, 16'h0, 1, 1, 1, 32'h0, 16'sd0);
    add_row(hcf_pkg::KIND_POINT, -32'sd65536, -32'sd65536, 16'h0, 16'h0, 1, 2, 0, 32'd65536,
            -16'sd12868);
    add_row(hcf_pkg::KIND_POINT, -32'sd131072, -32'sd65537, 16'h0, 16'h0, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'h8000_0000, 32'h8000_0000, 16'h5555, 16'hAAAA,
            0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 16'h0, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_START, 32'h0001_0000, 32'h0002_0000, 16'sd23170, 16'sd23170,
            0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'h0001_0001, 32'h0002_0001, 16'h0, 16'h0, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'h0001_0000, 32'h0002_0004, 16'h0, 16'h0, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_POINT, 32'h0001_0005, 32'h0001_FFFD, 16'h0, 16'h0, 0, 0, 0, 0, 0);
    add_row(hcf_pkg::KIND_START, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h0001,
            0, 0, 0, 0, 0);
    // difference too large for the sum of squares: distance saturates
    add_row(hcf_pkg::KIND_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0, 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[k]) begin
      row = stim_rows[k];
      push_word(row.word, has, rep);
      if (has) due_reports.push_back(row.typed ? row.want : rep);
    end

    thr_list[0] = 15'd25736;
    thr_list[1] = 15'd0;
    thr_list[2] = hcf_pkg::THRESH_W'($urandom_range(0, 25736));
    thr_list[3] = hcf_pkg::THRESH_W'($urandom_range(1, 2000));
    thr_list[4] = hcf_pkg::THRESH_RESET;
    thr_list[5] = 15'd12868;

    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      cfg_wr_data <= thr_list[phase];
      cfg_wr_en <= 1'b1;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      thresh_now = thr_list[phase];

      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        w.quat_z = 16'($urandom);
        w.quat_w = 16'($urandom);
        if (r < 8) begin
          w.kind = hcf_pkg::KIND_START;
          if ($urandom_range(0, 1)) begin
            cur_x = cur_x + rand_step();
            cur_y = cur_y + rand_step();
          end else begin
            cur_x = $urandom;
            cur_y = $urandom;
          end
          q = $urandom_range(0, 9);
          if (q == 0) begin
            w.quat_z = '0;
            w.quat_w = '0;
          end else if (q == 1) begin
            w.quat_z = pick_quat();
            w.quat_w = pick_quat();
          end
          step_x = rand_step();
          step_y = rand_step();
        end else begin
          w.kind = hcf_pkg::KIND_POINT;
          q = $urandom_range(0, 99);
          if (q < 45) begin
            // keep going along the same line
            cur_x = cur_x + step_x;
            cur_y = cur_y + step_y;
          end else if (q < 70) begin
            step_x = rand_step();
            step_y = rand_step();
            cur_x = cur_x + step_x;
            cur_y = cur_y + step_y;
          end else if (q < 78) begin
            step_x = step_x + $urandom_range(0, 16) - 8;
            step_y = step_y + $urandom_range(0, 16) - 8;
            cur_x = cur_x + step_x;
            cur_y = cur_y + step_y;
          end else if (q < 85) begin
            // repeat the last point
          end else if (q < 92) begin
            cur_x = $urandom;
            cur_y = $urandom;
          end else begin
            cur_x = pick_edge();
            cur_y = pick_edge();
          end
        end
        w.pos_x = cur_x;
        w.pos_y = cur_y;
        push_word(w, has, rep);
        if (has) due_reports.push_back(rep);
      end
    end

    wait_idle();
    if (mismatches == 0 && due_reports.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
